// ===== rtl/core/lifn_pkg.sv =====
`default_nettype none

package lifn_pkg;

    // Field widths
    localparam int DATA_W    = 32;
    localparam int DECAY_W   = 17;
    localparam int GAIN_W    = 31;
    localparam int REFR_W    = 10;
    localparam int DELAY_W   = 4;
    localparam int STEPIN_W  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_W    = 16;

    // Datapath widths: signed 32 x unsigned 31 product, and the exact four-term sum
    localparam int PROD_W = 63;
    localparam int ACC_W  = 49;

    // Refractory counter ceiling (all ones)
    localparam logic [REFR_W-1:0] REFR_CEIL = '1;

    // Input operation codes
    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_SPIKE   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTERIOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REFR      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY     = 3'd6;

    typedef struct packed {
        logic        [DECAY_W-1:0] decay_factor;
        logic        [GAIN_W-1:0]  drive_gain;
        logic signed [DATA_W-1:0]  inj_current;
        logic signed [DATA_W-1:0]  ext_input;
        logic signed [DATA_W-1:0]  fire_threshold;
        logic        [REFR_W-1:0]  refractory_steps;
        logic        [DELAY_W-1:0] spike_delay;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        decay_factor:      17'd65208,
        drive_gain:        31'd6554,
        inj_current:       32'sd0,
        ext_input:         32'sd0,
        fire_threshold:    32'sd1310720,
        refractory_steps:  10'd20,
        spike_delay:       4'd15
    };

    // Accumulator operations of the shared multiply-add unit
    typedef enum logic [2:0] {
        ALU_HOLD,
        ALU_LOAD,
        ALU_ADD,
        ALU_LOAD_PROD,
        ALU_ADD_PROD
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        logic    mul_en;
    } alu_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_MUL2,
        ST_ACC_DRIVE,
        ST_ACC_RING,
        ST_ACC_EXT,
        ST_SAT,
        ST_SPK_MOD,
        ST_SPK_LOAD,
        ST_SPK_ADD,
        ST_SPK_WRITE,
        ST_DONE
    } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/lifn_ram.sv =====
`default_nettype none

module lifn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lifn_alu.sv =====
`default_nettype none

module lifn_alu (
    input  logic                                   clk,
    input  lifn_pkg::alu_ctrl_t                    ctrl,
    input  logic signed [lifn_pkg::DATA_W-1:0]     mul_a,
    input  logic        [lifn_pkg::GAIN_W-1:0]     mul_b,
    input  logic signed [lifn_pkg::DATA_W-1:0]     add_in,
    output logic signed [lifn_pkg::DATA_W-1:0]     sat_out
);

    import lifn_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    logic signed [DATA_W-1:0]   mul_b_s;
    logic signed [2*DATA_W-1:0] mul_full;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W-1:0]    prod_term;
    logic signed [ACC_W-1:0]    oper_term;

    // Multiplier stage: signed word times unsigned factor
    assign mul_b_s   = $signed({1'b0, mul_b});
    assign mul_full  = mul_a * mul_b_s;
    assign prod_next = mul_full[PROD_W-1:0];

    // Floor of product / 2^16 is the arithmetic shift, sign extended
    assign prod_term = {{(ACC_W-(PROD_W-FRAC_W)){prod_reg[PROD_W-1]}},
                        prod_reg[PROD_W-1:FRAC_W]};
    assign oper_term = {{(ACC_W-DATA_W){add_in[DATA_W-1]}}, add_in};

    // Accumulator
    always_comb
    begin
        case (ctrl.op)
            ALU_LOAD:      acc_next = oper_term;
            ALU_ADD:       acc_next = acc_reg + oper_term;
            ALU_LOAD_PROD: acc_next = prod_term;
            ALU_ADD_PROD:  acc_next = acc_reg + prod_term;
            default:       acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    // Saturate the accumulator to a signed word
    always_comb
    begin
        if (acc_reg > SAT_HI)
        begin
            sat_out = SAT_HI[DATA_W-1:0];
        end
        else if (acc_reg < SAT_LO)
        begin
            sat_out = SAT_LO[DATA_W-1:0];
        end
        else
        begin
            sat_out = acc_reg[DATA_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lifn_seq.sv =====
`default_nettype none

module lifn_seq #(
    parameter int RING_DEPTH      = 16,
    parameter int RESET_POTENTIAL = 0,
    parameter int MAX_STEPS       = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lifn_pkg::cfg_t                         cfg,
    // input words
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   operation,
    input  logic [lifn_pkg::STEPIN_W-1:0]          step_count,
    input  logic [lifn_pkg::DATA_W-1:0]            sender_clock,
    input  logic signed [lifn_pkg::DATA_W-1:0]     strength,
    // result words
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   spiked,
    output logic signed [lifn_pkg::DATA_W-1:0]     potential,
    output logic                                   refractory,
    output logic [lifn_pkg::DATA_W-1:0]            fire_total,
    output logic [lifn_pkg::DATA_W-1:0]            step_clock,
    // shared multiply-add unit
    output lifn_pkg::alu_ctrl_t                    alu_ctrl,
    output logic signed [lifn_pkg::DATA_W-1:0]     mul_a,
    output logic [lifn_pkg::GAIN_W-1:0]            mul_b,
    output logic signed [lifn_pkg::DATA_W-1:0]     add_in,
    input  logic signed [lifn_pkg::DATA_W-1:0]     sat_out,
    // delay ring memory
    output logic                                   ram_wr_en,
    output logic [$clog2(RING_DEPTH)-1:0]          ram_wr_addr,
    output logic [lifn_pkg::DATA_W-1:0]            ram_wr_data,
    output logic                                   ram_rd_en,
    output logic [$clog2(RING_DEPTH)-1:0]          ram_rd_addr,
    input  logic [lifn_pkg::DATA_W-1:0]            ram_rd_data
);

    import lifn_pkg::*;

    localparam int IDX_W    = $clog2(RING_DEPTH);
    localparam int STEP_MAX = (MAX_STEPS < 31) ? MAX_STEPS : 31;
    localparam int CNT_W    = $clog2(STEP_MAX + 1);
    localparam int TGT_W    = $clog2(2 * RING_DEPTH + 16);

    localparam logic [IDX_W-1:0]    IDX_LAST   = IDX_W'(RING_DEPTH - 1);
    localparam logic [TGT_W-1:0]    TGT_DEPTH  = TGT_W'(RING_DEPTH);
    localparam logic [STEPIN_W-1:0] STEP_CLAMP = STEPIN_W'(STEP_MAX);
    localparam logic [CNT_W-1:0]    CNT_ONE    = CNT_W'(1);
    localparam logic signed [DATA_W-1:0] POT_RESET = DATA_W'(RESET_POTENTIAL);

    seq_state_t                state_reg, state_next;
    logic signed [DATA_W-1:0]  membrane_reg, membrane_next;
    logic [RING_DEPTH-1:0]     ring_valid_reg, ring_valid_next;
    logic [IDX_W-1:0]          ring_index_reg, ring_index_next;
    logic                      in_refr_reg, in_refr_next;
    logic [REFR_W-1:0]         refr_cnt_reg, refr_cnt_next;
    logic [DATA_W-1:0]         local_steps_reg, local_steps_next;
    logic [DATA_W-1:0]         fire_cnt_reg, fire_cnt_next;
    logic                      fired_reg, fired_next;
    logic [CNT_W-1:0]          steps_left_reg, steps_left_next;
    logic                      rd_valid_reg, rd_valid_next;
    logic [TGT_W-1:0]          tgt_reg, tgt_next;
    logic signed [DATA_W-1:0]  strength_reg, strength_next;

    logic [STEPIN_W-1:0]       step_clamped;
    logic [IDX_W-1:0]          idx_adv;
    logic [REFR_W-1:0]         refr_inc;
    logic                      last_step;
    logic                      same_step;
    logic signed [DATA_W-1:0]  ring_val;

    // Helpers
    assign step_clamped = (step_count > STEP_CLAMP) ? STEP_CLAMP : step_count;
    assign idx_adv      = (ring_index_reg == IDX_LAST) ? '0 : ring_index_reg + 1'b1;
    assign refr_inc     = (refr_cnt_reg == REFR_CEIL) ? refr_cnt_reg : refr_cnt_reg + 1'b1;
    assign last_step    = (steps_left_reg == CNT_ONE);
    assign same_step    = (sender_clock == local_steps_reg);
    // Slot never written since reset or since it was consumed reads as zero
    assign ring_val     = rd_valid_reg ? $signed(ram_rd_data) : '0;

    // Control and neuron state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            membrane_reg    <= POT_RESET;
            ring_valid_reg  <= '0;
            ring_index_reg  <= '0;
            in_refr_reg     <= 1'b0;
            refr_cnt_reg    <= '0;
            local_steps_reg <= '0;
            fire_cnt_reg    <= '0;
            fired_reg       <= 1'b0;
            steps_left_reg  <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            membrane_reg    <= membrane_next;
            ring_valid_reg  <= ring_valid_next;
            ring_index_reg  <= ring_index_next;
            in_refr_reg     <= in_refr_next;
            refr_cnt_reg    <= refr_cnt_next;
            local_steps_reg <= local_steps_next;
            fire_cnt_reg    <= fire_cnt_next;
            fired_reg       <= fired_next;
            steps_left_reg  <= steps_left_next;
            rd_valid_reg    <= rd_valid_next;
        end
    end

    // Spike word payload
    always_ff @(posedge clk)
    begin
        tgt_reg      <= tgt_next;
        strength_reg <= strength_next;
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        membrane_next    = membrane_reg;
        ring_valid_next  = ring_valid_reg;
        ring_index_next  = ring_index_reg;
        in_refr_next     = in_refr_reg;
        refr_cnt_next    = refr_cnt_reg;
        local_steps_next = local_steps_reg;
        fire_cnt_next    = fire_cnt_reg;
        fired_next       = fired_reg;
        steps_left_next  = steps_left_reg;
        tgt_next         = tgt_reg;
        strength_next    = strength_reg;

        alu_ctrl.op     = ALU_HOLD;
        alu_ctrl.mul_en = 1'b0;
        mul_a           = membrane_reg;
        mul_b           = GAIN_W'(cfg.decay_factor);
        add_in          = ring_val;

        ram_wr_en   = 1'b0;
        ram_wr_addr = tgt_reg[IDX_W-1:0];
        ram_wr_data = sat_out;
        ram_rd_en   = 1'b0;
        ram_rd_addr = ring_index_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    fired_next = 1'b0;
                    if (operation == OP_ADVANCE)
                    begin
                        steps_left_next = CNT_W'(step_clamped);
                        state_next = (step_clamped == '0) ? ST_DONE : ST_STEP;
                    end
                    else
                    begin
                        strength_next = strength;
                        tgt_next = TGT_W'(ring_index_reg) + TGT_W'(cfg.spike_delay)
                                 + TGT_DEPTH - TGT_W'(same_step);
                        state_next = ST_SPK_MOD;
                    end
                end
            end

            // One neuron step: refractory, fire, or start integrating
            ST_STEP:
            begin
                if (in_refr_reg)
                begin
                    refr_cnt_next = refr_inc;
                    if (refr_inc > cfg.refractory_steps)
                    begin
                        in_refr_next = 1'b0;
                    end
                    membrane_next    = '0;
                    local_steps_next = local_steps_reg + 1'b1;
                    steps_left_next  = steps_left_reg - 1'b1;
                    state_next       = last_step ? ST_DONE : ST_STEP;
                end
                else if (membrane_reg > cfg.fire_threshold)
                begin
                    in_refr_next    = 1'b1;
                    refr_cnt_next   = '0;
                    fire_cnt_next   = fire_cnt_reg + 1'b1;
                    fired_next      = 1'b1;
                    ring_valid_next[ring_index_reg] = 1'b0;
                    ring_index_next = idx_adv;
                    membrane_next    = '0;
                    local_steps_next = local_steps_reg + 1'b1;
                    steps_left_next  = steps_left_reg - 1'b1;
                    state_next       = last_step ? ST_DONE : ST_STEP;
                end
                else
                begin
                    // decay product, and fetch the current slot
                    ram_rd_en       = 1'b1;
                    alu_ctrl.mul_en = 1'b1;
                    state_next      = ST_MUL2;
                end
            end

            ST_MUL2:
            begin
                alu_ctrl.op     = ALU_LOAD_PROD;
                alu_ctrl.mul_en = 1'b1;
                mul_a           = cfg.inj_current;
                mul_b           = cfg.drive_gain;
                state_next      = ST_ACC_DRIVE;
            end

            ST_ACC_DRIVE:
            begin
                alu_ctrl.op = ALU_ADD_PROD;
                state_next  = ST_ACC_RING;
            end

            ST_ACC_RING:
            begin
                alu_ctrl.op = ALU_ADD;
                add_in      = ring_val;
                state_next  = ST_ACC_EXT;
            end

            ST_ACC_EXT:
            begin
                alu_ctrl.op = ALU_ADD;
                add_in      = cfg.ext_input;
                state_next  = ST_SAT;
            end

            // Commit integrated potential, consume the slot
            ST_SAT:
            begin
                membrane_next    = sat_out;
                ring_valid_next[ring_index_reg] = 1'b0;
                ring_index_next  = idx_adv;
                local_steps_next = local_steps_reg + 1'b1;
                steps_left_next  = steps_left_reg - 1'b1;
                state_next       = last_step ? ST_DONE : ST_STEP;
            end

            // Reduce target slot modulo ring depth, then fetch it
            ST_SPK_MOD:
            begin
                if (tgt_reg >= TGT_DEPTH)
                begin
                    tgt_next = tgt_reg - TGT_DEPTH;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = tgt_reg[IDX_W-1:0];
                    state_next  = ST_SPK_LOAD;
                end
            end

            ST_SPK_LOAD:
            begin
                alu_ctrl.op = ALU_LOAD;
                add_in      = ring_val;
                state_next  = ST_SPK_ADD;
            end

            ST_SPK_ADD:
            begin
                alu_ctrl.op = ALU_ADD;
                add_in      = strength_reg;
                state_next  = ST_SPK_WRITE;
            end

            ST_SPK_WRITE:
            begin
                ram_wr_en  = 1'b1;
                ring_valid_next[tgt_reg[IDX_W-1:0]] = 1'b1;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rd_valid_next = ram_rd_en ? ring_valid_reg[ram_rd_addr] : rd_valid_reg;
    end

    // Handshake and result word
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = (state_reg == ST_DONE);
    assign spiked     = fired_reg;
    assign potential  = membrane_reg;
    assign refractory = in_refr_reg;
    assign fire_total = fire_cnt_reg;
    assign step_clock = local_steps_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lif_neuron_with_delay_ring_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake            Word
// in        input      in_valid / in_stall  operation, step_count, sender_clock, strength
// out       output     out_valid/out_stall  spiked, potential, refractory, fire_total, step_clock
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word at a time; in_stall is high from acceptance until the result is taken.
// Every word is accepted in idle and presents its result in the done state until taken.
// Advance: a refractory or firing step is done in the step state alone; an integrating step
// runs two products, three adds, then the saturated commit (at most sixteen steps by default).
// Spike: reduce the target slot by ring depth (0-2 times at depth 16), then load, add, write.
// Reset clears state at once: no clearing pass; ring slots carry valid bits.

module lif_neuron_with_delay_ring_unit #(
    parameter int RING_DEPTH      = 16,
    parameter int RESET_POTENTIAL = 0,
    parameter int MAX_STEPS       = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input words
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   operation,
    input  logic [lifn_pkg::STEPIN_W-1:0]          step_count,
    input  logic [lifn_pkg::DATA_W-1:0]            sender_clock,
    input  logic signed [lifn_pkg::DATA_W-1:0]     strength,
    // result words
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   spiked,
    output logic signed [lifn_pkg::DATA_W-1:0]     potential,
    output logic                                   refractory,
    output logic [lifn_pkg::DATA_W-1:0]            fire_total,
    output logic [lifn_pkg::DATA_W-1:0]            step_clock,
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [lifn_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lifn_pkg::DATA_W-1:0]            cfg_data
);

    import lifn_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);

    cfg_t                     cfg_reg, cfg_next;
    alu_ctrl_t                alu_ctrl;
    logic signed [DATA_W-1:0] mul_a;
    logic [GAIN_W-1:0]        mul_b;
    logic signed [DATA_W-1:0] add_in;
    logic signed [DATA_W-1:0] sat_out;
    logic                     ram_wr_en;
    logic [IDX_W-1:0]         ram_wr_addr;
    logic [DATA_W-1:0]        ram_wr_data;
    logic                     ram_rd_en;
    logic [IDX_W-1:0]         ram_rd_addr;
    logic [DATA_W-1:0]        ram_rd_data;

    // Configuration registers; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DECAY:     cfg_next.decay_factor      = cfg_data[DECAY_W-1:0];
                REG_GAIN:      cfg_next.drive_gain        = cfg_data[GAIN_W-1:0];
                REG_CURRENT:   cfg_next.inj_current       = $signed(cfg_data);
                REG_EXTERIOR:  cfg_next.ext_input         = $signed(cfg_data);
                REG_THRESHOLD: cfg_next.fire_threshold    = $signed(cfg_data);
                REG_REFR:      cfg_next.refractory_steps  = cfg_data[REFR_W-1:0];
                REG_DELAY:     cfg_next.spike_delay       = cfg_data[DELAY_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lifn_seq #(
        .RING_DEPTH      (RING_DEPTH),
        .RESET_POTENTIAL (RESET_POTENTIAL),
        .MAX_STEPS       (MAX_STEPS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .step_count   (step_count),
        .sender_clock (sender_clock),
        .strength     (strength),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .spiked       (spiked),
        .potential    (potential),
        .refractory   (refractory),
        .fire_total   (fire_total),
        .step_clock   (step_clock),
        .alu_ctrl     (alu_ctrl),
        .mul_a        (mul_a),
        .mul_b        (mul_b),
        .add_in       (add_in),
        .sat_out      (sat_out),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    lifn_alu u_alu (
        .clk     (clk),
        .ctrl    (alu_ctrl),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .add_in  (add_in),
        .sat_out (sat_out)
    );

    lifn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire
